FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/qwfc_pkg.sv
// ---------------------------------------------------------------------------
// qwfc_pkg
// types, codes, constants and helper functions of the flight controller
// ---------------------------------------------------------------------------
package qwfc_pkg;

  // input actions
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_TOGGLE = 2'd1;
  localparam logic [1:0] ACT_WRITE  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_WP_COUNT  = 3'd0;
  localparam logic [2:0] REG_ARR_RAD   = 3'd1;
  localparam logic [2:0] REG_OBST_RNG  = 3'd2;
  localparam logic [2:0] REG_HOVER     = 3'd3;
  localparam logic [2:0] REG_ALT_OFS   = 3'd4;
  localparam logic [2:0] REG_ALT_GAIN  = 3'd5;
  localparam logic [2:0] REG_ROLL_GAIN = 3'd6;
  localparam logic [2:0] REG_PITCH_GAIN = 3'd7;

  localparam int PI_Q       = 25736;
  localparam int TWO_PI_Q   = 51472;
  localparam int FWD_WINDOW = 6554;
  localparam int FWD_HALF   = 3277;
  localparam int LAND_CUT   = 38;
  localparam int ALT_WINDOW = 128;
  localparam int OBST_LIFT  = 20;
  localparam int RANGE_FLOOR = 25;
  localparam int ONE_Q21    = 2097152;
  localparam int HALF_Q21   = 1048576;
  localparam int ANG_LIM    = 8192;
  localparam int ERR_LIM    = 256;
  localparam int OUT_MAX    = 131071;
  localparam int OUT_MIN    = -131072;
  localparam int CORD_LAST  = 13;
  localparam longint FWD_RECIP = (64'd1 << 41) / FWD_HALF;

  typedef struct packed {
    logic [4:0]  waypoint_count;
    logic [15:0] arrival_radius;
    logic [15:0] obstacle_range;
    logic [15:0] hover_thrust;
    logic signed [15:0] altitude_offset;
    logic [15:0] altitude_gain;
    logic [15:0] roll_gain;
    logic [15:0] pitch_gain;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIFF, OP_SQX, OP_SQY, OP_SQR, OP_ARR, OP_CORD, OP_HE,
    OP_PC1, OP_PC2, OP_PC3, OP_ERR, OP_E2, OP_E3, OP_E4, OP_RG, OP_PG, OP_MIX,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic       accept;
    op_t        op;
    logic [3:0] iter;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic landing;
    logic landed;
  } sts_t;

  function automatic logic [12:0] atan_val(input logic [3:0] i);
    logic [12:0] v;
    case (i)
      4'd0:  v = 13'd6434;
      4'd1:  v = 13'd3798;
      4'd2:  v = 13'd2007;
      4'd3:  v = 13'd1019;
      4'd4:  v = 13'd511;
      4'd5:  v = 13'd256;
      4'd6:  v = 13'd128;
      4'd7:  v = 13'd64;
      4'd8:  v = 13'd32;
      4'd9:  v = 13'd16;
      4'd10: v = 13'd8;
      4'd11: v = 13'd4;
      4'd12: v = 13'd2;
      4'd13: v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

  // round q.21 to q.8, ties up, then saturate
  function automatic logic signed [17:0] motor_sat(input logic signed [35:0] v);
    logic signed [35:0] t;
    t = (v + 36'sd4096) >>> 13;
    if (t > OUT_MAX) return 18'sd131071;
    if (t < OUT_MIN) return -18'sd131072;
    return 18'(t);
  endfunction

endpackage

FILE: rtl/quadcopter_waypoint_flight_controller_unit.sv
// ---------------------------------------------------------------------------
// quadcopter_waypoint_flight_controller_unit
// waypoint steering and motor mixing controller, one result word per tick
// ---------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one word per control tick, toggle tick
//   or waypoint write. a waypoint write goes to the route memory and gives no
//   result word. a tick gives exactly one result word on the out_ channel.
//   in flight a tick runs 14 cordic steps, one step a cycle; when landing it
//   skips the steering, and once landed it goes straight to the result word.
//   the shared multiplier runs one product a cycle. the next word is taken
//   once a tick is done, while its result may wait in the output register.
//   reset: flight mode, waypoint index zero, registers at their defaults.
//   route slots hold nothing until written; no clearing pass is run.
//   receiver stall: the result word holds; a following tick completes its
//   work and waits for the output register before in_ready returns.
//   configuration: apb-style, pready tied high; written only while idle, a
//   rule for the user that the block itself does not enforce.
// ---------------------------------------------------------------------------
module quadcopter_waypoint_flight_controller_unit #(
  parameter int ROUTE_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [3:0]         in_waypoint_slot,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [15:0] in_pitch_angle,
  input  logic signed [15:0] in_heading_angle,
  input  logic signed [15:0] in_roll_rate,
  input  logic signed [15:0] in_pitch_rate,
  input  logic signed [15:0] in_yaw_rate,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_altitude,
  input  logic [15:0]        in_center_range,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] out_motor_front_left,
  output logic signed [17:0] out_motor_front_right,
  output logic signed [17:0] out_motor_rear_left,
  output logic signed [17:0] out_motor_rear_right,
  output logic [3:0]         out_active_waypoint,
  output logic               out_landing_active,
  output logic               out_motors_cut
);
  import qwfc_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.waypoint_count  <= 5'd2;
      cfg_r.arrival_radius  <= 16'd256;
      cfg_r.obstacle_range  <= 16'd384;
      cfg_r.hover_thrust    <= 16'd17536;
      cfg_r.altitude_offset <= 16'sd154;
      cfg_r.altitude_gain   <= 16'd768;
      cfg_r.roll_gain       <= 16'd12800;
      cfg_r.pitch_gain      <= 16'd7680;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_WP_COUNT:   cfg_r.waypoint_count  <= pwdata[4:0];
        REG_ARR_RAD:    cfg_r.arrival_radius  <= pwdata[15:0];
        REG_OBST_RNG:   cfg_r.obstacle_range  <= pwdata[15:0];
        REG_HOVER:      cfg_r.hover_thrust    <= pwdata[15:0];
        REG_ALT_OFS:    cfg_r.altitude_offset <= pwdata[15:0];
        REG_ALT_GAIN:   cfg_r.altitude_gain   <= pwdata[15:0];
        REG_ROLL_GAIN:  cfg_r.roll_gain       <= pwdata[15:0];
        REG_PITCH_GAIN: cfg_r.pitch_gain      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_WP_COUNT:   prdata = {27'b0, cfg_r.waypoint_count};
      REG_ARR_RAD:    prdata = {16'b0, cfg_r.arrival_radius};
      REG_OBST_RNG:   prdata = {16'b0, cfg_r.obstacle_range};
      REG_HOVER:      prdata = {16'b0, cfg_r.hover_thrust};
      REG_ALT_OFS:    prdata = 32'(cfg_r.altitude_offset);
      REG_ALT_GAIN:   prdata = {16'b0, cfg_r.altitude_gain};
      REG_ROLL_GAIN:  prdata = {16'b0, cfg_r.roll_gain};
      REG_PITCH_GAIN: prdata = {16'b0, cfg_r.pitch_gain};
      default:        prdata = 32'd0;
    endcase
  end

  qwfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qwfc_dp #(
    .ROUTE_SLOTS (ROUTE_SLOTS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg                   (cfg_r),
    .in_action             (in_action),
    .in_waypoint_slot      (in_waypoint_slot),
    .in_roll_angle         (in_roll_angle),
    .in_pitch_angle        (in_pitch_angle),
    .in_heading_angle      (in_heading_angle),
    .in_roll_rate          (in_roll_rate),
    .in_pitch_rate         (in_pitch_rate),
    .in_yaw_rate           (in_yaw_rate),
    .in_pos_x              (in_pos_x),
    .in_pos_y              (in_pos_y),
    .in_altitude           (in_altitude),
    .in_center_range       (in_center_range),
    .out_motor_front_left  (out_motor_front_left),
    .out_motor_front_right (out_motor_front_right),
    .out_motor_rear_left   (out_motor_rear_left),
    .out_motor_rear_right  (out_motor_rear_right),
    .out_active_waypoint   (out_active_waypoint),
    .out_landing_active    (out_landing_active),
    .out_motors_cut        (out_motors_cut)
  );

endmodule

FILE: rtl/qwfc_ctrl.sv
// ---------------------------------------------------------------------------
// qwfc_ctrl
// sequencer: steps the datapath through one control tick and owns the handshakes
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qwfc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_action,
  output logic             out_valid,
  input  logic             out_ready,
  input  qwfc_pkg::sts_t   sts,
  output qwfc_pkg::cmd_t   cmd
);
  import qwfc_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001, S_LOAD = 20'h00002, S_DIFF = 20'h00004, S_SQX = 20'h00008,
    S_SQY  = 20'h00010, S_SQR  = 20'h00020, S_ARR  = 20'h00040, S_CORD = 20'h00080,
    S_HE   = 20'h00100, S_PC1  = 20'h00200, S_PC2  = 20'h00400, S_PC3  = 20'h00800,
    S_ERR  = 20'h01000, S_E2   = 20'h02000, S_E3   = 20'h04000, S_E4   = 20'h08000,
    S_RG   = 20'h10000, S_PG   = 20'h20000, S_MIX  = 20'h40000, S_OUT  = 20'h80000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] iter_r, iter_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, load_out;
  logic       tick_go, cord_done;
  op_t        op;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign tick_go   = accept && (in_action == ACT_TICK || in_action == ACT_TOGGLE);
  assign cord_done = (iter_r == 4'(CORD_LAST));
  assign load_out  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (tick_go) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        op = OP_LOAD;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        op = OP_DIFF;
        if (sts.landed) state_nxt = S_OUT;
        else if (sts.landing) state_nxt = S_ERR;
        else state_nxt = S_SQX;
      end
      S_SQX: begin
        op = OP_SQX;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        op = OP_SQY;
        state_nxt = S_SQR;
      end
      S_SQR: begin
        op = OP_SQR;
        state_nxt = S_ARR;
      end
      S_ARR: begin
        op = OP_ARR;
        iter_nxt = 4'd0;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        op = OP_CORD;
        iter_nxt = iter_r + 4'd1;
        if (cord_done) state_nxt = S_HE;
      end
      S_HE: begin
        op = OP_HE;
        state_nxt = S_PC1;
      end
      S_PC1: begin
        op = OP_PC1;
        state_nxt = S_PC2;
      end
      S_PC2: begin
        op = OP_PC2;
        state_nxt = S_PC3;
      end
      S_PC3: begin
        op = OP_PC3;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        op = OP_ERR;
        state_nxt = S_E2;
      end
      S_E2: begin
        op = OP_E2;
        state_nxt = S_E3;
      end
      S_E3: begin
        op = OP_E3;
        state_nxt = S_E4;
      end
      S_E4: begin
        op = OP_E4;
        state_nxt = S_RG;
      end
      S_RG: begin
        op = OP_RG;
        state_nxt = S_PG;
      end
      S_PG: begin
        op = OP_PG;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        op = OP_MIX;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        op = OP_OUT;
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  assign cmd.accept   = accept;
  assign cmd.op       = op;
  assign cmd.iter     = iter_r;
  assign cmd.load_out = load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `QW_ASSERT_NEXT(a_tick_starts, tick_go, state_r == S_LOAD, "accepted tick did not start")
  `QW_ASSERT_IMPL(a_out_rise, $rose(out_valid_r), $past(state_r) == S_OUT, "stray result word")
  `QW_ASSERT_NEXT(a_cordic_len, state_r == S_CORD && cord_done, state_r == S_HE, "cordic length")

endmodule

FILE: rtl/qwfc_dp.sv
// ---------------------------------------------------------------------------
// qwfc_dp
// datapath: route memory, shared multiplier, cordic bearing, mixing, result word
// ---------------------------------------------------------------------------
module qwfc_dp #(
  parameter int ROUTE_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qwfc_pkg::cmd_t      cmd,
  output qwfc_pkg::sts_t      sts,
  input  qwfc_pkg::cfg_t      cfg,
  input  logic [1:0]          in_action,
  input  logic [3:0]          in_waypoint_slot,
  input  logic signed [15:0]  in_roll_angle,
  input  logic signed [15:0]  in_pitch_angle,
  input  logic signed [15:0]  in_heading_angle,
  input  logic signed [15:0]  in_roll_rate,
  input  logic signed [15:0]  in_pitch_rate,
  input  logic signed [15:0]  in_yaw_rate,
  input  logic signed [23:0]  in_pos_x,
  input  logic signed [23:0]  in_pos_y,
  input  logic signed [23:0]  in_altitude,
  input  logic [15:0]         in_center_range,
  output logic signed [17:0]  out_motor_front_left,
  output logic signed [17:0]  out_motor_front_right,
  output logic signed [17:0]  out_motor_rear_left,
  output logic signed [17:0]  out_motor_rear_right,
  output logic [3:0]          out_active_waypoint,
  output logic                out_landing_active,
  output logic                out_motors_cut
);
  import qwfc_pkg::*;

  localparam int SW    = $clog2(ROUTE_SLOTS);
  localparam int LIMIT = (ROUTE_SLOTS < 16) ? ROUTE_SLOTS : 16;

  logic [71:0] route_mem [ROUTE_SLOTS];
  logic [71:0] rd_r;

  logic       landing_r;
  logic [3:0] tidx_r;

  logic signed [15:0] roll_r, pitch_r, head_r, rrate_r, prate_r, yrate_r;
  logic signed [23:0] px_r, py_r, alt_r;
  logic [15:0]        range_r;

  logic signed [24:0] dx_r, dy_r;
  logic signed [25:0] tz_r;
  logic               dz_ok_r, zero_r;
  logic [51:0]        acc_r;
  logic signed [35:0] x_r, y_r;
  logic signed [16:0] z_r;
  logic signed [22:0] yaw_r;
  logic               pflag_r;
  logic [12:0]        n_r;
  logic [22:0]        qe_r;
  logic signed [23:0] pcmd_r;
  logic signed [9:0]  err_r;
  logic signed [31:0] ain_r, rin_r, pin_r, base_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] ma, mb;

  logic [4:0] cnt;
  logic [3:0] max_idx;
  logic [4:0] tinc;

  // waypoint count limits
  always_comb begin
    if (cfg.waypoint_count == 5'd0) cnt = 5'd1;
    else if (cfg.waypoint_count > 5'(LIMIT)) cnt = 5'(LIMIT);
    else cnt = cfg.waypoint_count;
  end
  assign max_idx = 4'(cnt - 5'd1);
  assign tinc    = {1'b0, tidx_r} + 5'd1;

  // route entry fields
  logic signed [23:0] wx, wy, wz;
  assign wx = rd_r[71:48];
  assign wy = rd_r[47:24];
  assign wz = rd_r[23:0];

  logic signed [24:0] dx_w, dy_w, dz_w;
  assign dx_w = 25'(wx) - 25'(px_r);
  assign dy_w = 25'(wy) - 25'(py_r);
  assign dz_w = 25'(alt_r) - 25'(wz);

  // heading error and wrap
  logic signed [18:0] he0, he1, he2;
  logic signed [16:0] he_w, ha;
  logic signed [29:0] yraw;
  logic               obst;
  always_comb begin
    he0 = (zero_r ? 19'sd0 : 19'(z_r)) - 19'(head_r);
    if (he0 > PI_Q) he1 = 19'(he0 - TWO_PI_Q);
    else if (he0 < -PI_Q) he1 = 19'(he0 + TWO_PI_Q);
    else he1 = he0;
    if (he1 > PI_Q) he2 = 19'(he1 - TWO_PI_Q);
    else if (he1 < -PI_Q) he2 = 19'(he1 + TWO_PI_Q);
    else he2 = he1;
    he_w = 17'(he2);
    ha   = (he_w < 0) ? -he_w : he_w;
    yraw = (30'(he_w) <<< 9) - (30'(yrate_r) <<< 12) - (30'(yrate_r) <<< 10);
    obst = (range_r < cfg.obstacle_range) && (range_r > 16'(RANGE_FLOOR));
  end

  // forward pitch quotient correction
  logic [35:0] rem_w;
  logic [22:0] q_w;
  assign rem_w = ({23'b0, n_r} << 21) - prod_r[35:0];
  assign q_w   = qe_r + ((rem_w >= 36'(FWD_HALF)) ? 23'd1 : 23'd0);

  logic signed [27:0] e_w;
  assign e_w = 28'(tz_r) - 28'(alt_r) + 28'(cfg.altitude_offset);

  logic signed [15:0] rollc, pitchc;
  always_comb begin
    if (roll_r > ANG_LIM) rollc = 16'sd8192;
    else if (roll_r < -ANG_LIM) rollc = -16'sd8192;
    else rollc = roll_r;
    if (pitch_r > ANG_LIM) pitchc = 16'sd8192;
    else if (pitch_r < -ANG_LIM) pitchc = -16'sd8192;
    else pitchc = pitch_r;
  end

  // shared multiplier operands
  always_comb begin
    ma = 32'sd0;
    mb = 32'sd0;
    case (cmd.op)
      OP_SQX: begin
        ma = 32'(dx_r);
        mb = 32'(dx_r);
      end
      OP_SQY: begin
        ma = 32'(dy_r);
        mb = 32'(dy_r);
      end
      OP_SQR: begin
        ma = {16'b0, cfg.arrival_radius};
        mb = {16'b0, cfg.arrival_radius};
      end
      OP_PC1: begin
        ma = {19'b0, n_r};
        mb = 32'(FWD_RECIP);
      end
      OP_PC2: begin
        ma = {9'b0, prod_r[42:20]};
        mb = 32'(FWD_HALF);
      end
      OP_E2: begin
        ma = 32'(err_r);
        mb = 32'(err_r);
      end
      OP_E3: begin
        ma = prod_r[31:0];
        mb = 32'(err_r);
      end
      OP_E4: begin
        ma = prod_r[31:0];
        mb = {16'b0, cfg.altitude_gain};
      end
      OP_RG: begin
        ma = {16'b0, cfg.roll_gain};
        mb = 32'(rollc);
      end
      OP_PG: begin
        ma = {16'b0, cfg.pitch_gain};
        mb = 32'(pitchc);
      end
      default: begin
        ma = 32'sd0;
        mb = 32'sd0;
      end
    endcase
  end

  // mixing
  logic signed [35:0] fl, fr, rl, rr;
  assign fl = 36'(base_r) - 36'(rin_r) + 36'(pin_r) - 36'(yaw_r);
  assign fr = 36'(base_r) + 36'(rin_r) + 36'(pin_r) + 36'(yaw_r);
  assign rl = 36'(base_r) - 36'(rin_r) - 36'(pin_r) + 36'(yaw_r);
  assign rr = 36'(base_r) + 36'(rin_r) - 36'(pin_r) - 36'(yaw_r);

  assign sts.landing = landing_r;
  assign sts.landed  = landing_r && (alt_r <= LAND_CUT);

  // route memory
  always_ff @(posedge clk) begin
    if (cmd.accept && in_action == ACT_WRITE && 32'(in_waypoint_slot) < ROUTE_SLOTS) begin
      route_mem[SW'(in_waypoint_slot)] <= {in_pos_x, in_pos_y, in_altitude};
    end
    if (cmd.op == OP_LOAD) rd_r <= route_mem[SW'(tidx_r)];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      landing_r <= 1'b0;
      tidx_r    <= 4'd0;
    end else begin
      if (cmd.accept && (in_action == ACT_TICK || in_action == ACT_TOGGLE)) begin
        if (in_action == ACT_TOGGLE) landing_r <= !landing_r;
        if ({1'b0, tidx_r} >= cnt) tidx_r <= max_idx;
      end
      if (cmd.op == OP_ARR && acc_r < prod_r[51:0] && dz_ok_r) begin
        tidx_r <= (tinc >= cnt) ? max_idx : 4'(tinc);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (cmd.accept) begin
      roll_r  <= in_roll_angle;
      pitch_r <= in_pitch_angle;
      head_r  <= in_heading_angle;
      rrate_r <= in_roll_rate;
      prate_r <= in_pitch_rate;
      yrate_r <= in_yaw_rate;
      px_r    <= in_pos_x;
      py_r    <= in_pos_y;
      alt_r   <= in_altitude;
      range_r <= in_center_range;
    end
    case (cmd.op)
      OP_DIFF: begin
        dx_r    <= dx_w;
        dy_r    <= dy_w;
        tz_r    <= landing_r ? 26'sd0 : 26'(wz);
        dz_ok_r <= (dz_w < ALT_WINDOW) && (dz_w > -ALT_WINDOW);
        yaw_r   <= 23'sd0;
        pcmd_r  <= 24'sd0;
      end
      OP_SQY: acc_r <= prod_r[51:0];
      OP_SQR: acc_r <= acc_r + prod_r[51:0];
      OP_ARR: begin
        zero_r <= (dx_r == 0) && (dy_r == 0);
        if (dx_r < 0) begin
          x_r <= -(36'(dx_r) <<< 8);
          y_r <= -(36'(dy_r) <<< 8);
          z_r <= (dy_r >= 0) ? 17'sd25736 : -17'sd25736;
        end else begin
          x_r <= 36'(dx_r) <<< 8;
          y_r <= 36'(dy_r) <<< 8;
          z_r <= 17'sd0;
        end
      end
      OP_CORD: begin
        if (y_r >= 0) begin
          x_r <= x_r + (y_r >>> cmd.iter);
          y_r <= y_r - (x_r >>> cmd.iter);
          z_r <= z_r + 17'(atan_val(cmd.iter));
        end else begin
          x_r <= x_r - (y_r >>> cmd.iter);
          y_r <= y_r + (x_r >>> cmd.iter);
          z_r <= z_r - 17'(atan_val(cmd.iter));
        end
      end
      OP_HE: begin
        if (obst) begin
          tz_r    <= tz_r + 26'(OBST_LIFT);
          yaw_r   <= 23'sd0;
          pflag_r <= 1'b0;
        end else begin
          if (yraw > ONE_Q21) yaw_r <= 23'(ONE_Q21);
          else if (yraw < -ONE_Q21) yaw_r <= 23'(-ONE_Q21);
          else yaw_r <= 23'(yraw);
          pflag_r <= (ha < FWD_WINDOW);
        end
        n_r <= 13'(FWD_WINDOW - ha);
      end
      OP_PC2: qe_r <= prod_r[42:20];
      OP_PC3: begin
        if (!pflag_r) pcmd_r <= 24'sd0;
        else if (q_w < 23'(HALF_Q21)) pcmd_r <= -24'sd1048576;
        else pcmd_r <= -$signed({1'b0, q_w});
      end
      OP_ERR: begin
        if (e_w > ERR_LIM) err_r <= 10'sd256;
        else if (e_w < -ERR_LIM) err_r <= -10'sd256;
        else err_r <= 10'(e_w);
      end
      OP_RG: ain_r <= 32'(prod_r >>> 11);
      OP_PG: rin_r <= 32'(prod_r) + (32'(rrate_r) <<< 10);
      OP_MIX: begin
        pin_r  <= 32'(prod_r) + (32'(prate_r) <<< 10) + 32'(pcmd_r);
        base_r <= $signed({3'b0, cfg.hover_thrust, 13'b0}) + ain_r;
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      out_motor_front_left  <= sts.landed ? 18'sd0 : motor_sat(fl);
      out_motor_front_right <= sts.landed ? 18'sd0 : motor_sat(-fr);
      out_motor_rear_left   <= sts.landed ? 18'sd0 : motor_sat(-rl);
      out_motor_rear_right  <= sts.landed ? 18'sd0 : motor_sat(rr);
      out_active_waypoint   <= tidx_r;
      out_landing_active    <= landing_r;
      out_motors_cut        <= sts.landed;
    end
  end

endmodule
